### hdl/vtpt_pkg.sv
// Shared constants, types and a helper function for the voltage to pot tap converter.
package vtpt_pkg;

    // Field and register widths
    localparam int CV_W     = 16;
    localparam int BASE_W   = 11;
    localparam int GAIN_W   = 19;
    localparam int OFFSET_W = 14;
    localparam int TAP_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_BASE_MV    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIT_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_OFFSET = 2'd2;

    // Reset values of the calibration registers
    localparam logic [BASE_W-1:0]   BASE_MV_RST    = 11'd400;
    localparam logic [GAIN_W-1:0]   FIT_GAIN_RST   = 19'd100000;
    localparam logic [OFFSET_W-1:0] TAP_OFFSET_RST = 14'd0;

    // Request clamp limits in centivolts
    localparam logic [CV_W-1:0] CV_MIN = 16'd1;
    localparam logic [CV_W-1:0] CV_MAX = 16'd550;

    // Millivolts (5500 max) and the divider geometry
    localparam int MV_W        = 13;
    localparam int NUM_W       = 32;
    localparam int QUOT_W      = 30;
    localparam int BITS_PER_ST = 4;
    localparam int DIV_STAGES  = NUM_W / BITS_PER_ST;

    // Gain times 1000 fits in 29 bits
    localparam int GAIN_K_W = 29;

    // Output scaling
    localparam logic [TAP_W-1:0] TAP_MAX   = 7'd127;
    localparam logic [9:0]       MILLI     = 10'd1000;
    localparam logic [QUOT_W-1:0] HALF_MILLI = 30'd500;
    // Rounded tap reaches TAP_MAX + 1 once offset-corrected value plus half hits this
    localparam logic [QUOT_W-1:0] SAT_LIMIT  = 30'd128000;
    // Divide-by-1000 by reciprocal: x * RECIP >> RECIP_SH, exact for x < 131072
    localparam int X_W      = 17;
    localparam int RECIP_W  = 18;
    localparam int PROD_W   = X_W + RECIP_W;
    localparam int RECIP_SH = 27;
    localparam logic [RECIP_W-1:0] RECIP = 18'd134218;

    // One divider pipeline stage
    typedef struct packed {
        logic            at_max;
        logic [MV_W-1:0] dvs;
        logic [MV_W-1:0] rem;
        logic [NUM_W-1:0] nq;
    } div_stage_t;

    // Run BITS_PER_ST restoring-division steps: numerator bits leave the top of nq,
    // quotient bits enter at the bottom
    function automatic div_stage_t div_step(input div_stage_t st_in);
        div_stage_t    st;
        logic [MV_W:0] rs;
        st = st_in;
        for (int k = 0; k < BITS_PER_ST; k++) begin
            rs = {st.rem, st.nq[NUM_W-1]};
            if (rs >= {1'b0, st.dvs}) begin
                st.rem = MV_W'(rs - {1'b0, st.dvs});
                st.nq  = {st.nq[NUM_W-2:0], 1'b1};
            end else begin
                st.rem = rs[MV_W-1:0];
                st.nq  = {st.nq[NUM_W-2:0], 1'b0};
            end
        end
        return st;
    endfunction

endpackage

### hdl/voltage_to_pot_tap_unit.sv
// Top level of the voltage to pot tap converter: a fully pipelined datapath.
//
// Converts a requested supply voltage in centivolts (clamped to 1..550) into a
// 7-bit potentiometer tap code from the calibration registers base_millivolts,
// fit_gain and tap_offset_milli. The block takes one item per clock while the
// output does not stall, and presents its tap through thirteen register stages,
// the first loaded at acceptance: two front stages (clamp and scaling,
// numerator forming), eight divider stages of four quotient bits each, and
// three back stages (offset and rounding, reciprocal multiply, output register).
// The pipeline advances as a whole whenever the output register is empty or
// being taken, so s_tready drops only while a result waits at the output.
// Calibration registers are written on the cfg channel, which is always ready;
// write them only while no item is in flight. Unknown register indexes are ignored.
module voltage_to_pot_tap_unit
    import vtpt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,    // [15:0] target_centivolts
    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,    // [6:0] tap_value, [7] zero
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Calibration registers
    logic [BASE_W-1:0]   base_mv_reg;
    logic [GAIN_W-1:0]   fit_gain_reg;
    logic [OFFSET_W-1:0] tap_offset_reg;

    // Pipeline advance
    logic adv;

    // Stage A: clamp, scale, compare with base
    logic                a_valid_reg;
    logic                a_max_reg;
    logic [MV_W-1:0]     a_excess_reg;
    logic [GAIN_K_W-1:0] a_gain_k_reg;
    logic [CV_W-1:0]     cv_clamp;
    logic [MV_W-1:0]     mv_next;

    // Divider stages; index 0 is the loaded numerator
    logic [DIV_STAGES:0] dv_valid_reg;
    div_stage_t          dv_reg [0:DIV_STAGES];
    div_stage_t          dv_next [0:DIV_STAGES];

    // Stage P1: offset, rounding, saturation check
    logic             p1_valid_reg;
    logic             p1_max_reg;
    logic             p1_zero_reg;
    logic             p1_sat_reg;
    logic [X_W-1:0]   p1_x_reg;
    logic [QUOT_W-1:0] quot;
    logic [QUOT_W-1:0] x_next;

    // Stage P2: reciprocal multiply
    logic              p2_valid_reg;
    logic              p2_max_reg;
    logic              p2_zero_reg;
    logic              p2_sat_reg;
    logic [PROD_W-1:0] p2_prod_reg;

    // Output register
    logic             m_tvalid_reg;
    logic [TAP_W-1:0] tap_reg;
    logic [TAP_W-1:0] tap_next;

    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {1'b0, tap_reg};

    // Write calibration registers; drop unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_mv_reg    <= BASE_MV_RST;
            fit_gain_reg   <= FIT_GAIN_RST;
            tap_offset_reg <= TAP_OFFSET_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BASE_MV:    base_mv_reg    <= cfg_data[BASE_W-1:0];
                REG_FIT_GAIN:   fit_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_TAP_OFFSET: tap_offset_reg <= cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the request and scale to millivolts (times 8 plus times 2)
    always_comb begin
        if (s_tdata < CV_MIN) begin
            cv_clamp = CV_MIN;
        end else if (s_tdata > CV_MAX) begin
            cv_clamp = CV_MAX;
        end else begin
            cv_clamp = s_tdata;
        end
        mv_next = MV_W'({cv_clamp, 3'b000}) + MV_W'({cv_clamp, 1'b0});
    end

    // Divider recurrence between stages
    always_comb begin
        dv_next[0] = dv_reg[0];
        for (int i = 0; i < DIV_STAGES; i++) begin
            dv_next[i+1] = div_step(dv_reg[i]);
        end
    end

    // Offset-corrected, half-rounded milli-taps
    assign quot   = dv_reg[DIV_STAGES].nq[QUOT_W-1:0];
    assign x_next = quot - QUOT_W'(tap_offset_reg) + HALF_MILLI;

    // Final tap selection; an offset that swallows the milli-taps wins over saturation
    always_comb begin
        if (p2_max_reg) begin
            tap_next = TAP_MAX;
        end else if (p2_zero_reg) begin
            tap_next = '0;
        end else if (p2_sat_reg) begin
            tap_next = TAP_MAX;
        end else begin
            tap_next = p2_prod_reg[RECIP_SH +: TAP_W];
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            dv_valid_reg <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg  <= s_tvalid;
            dv_valid_reg <= {dv_valid_reg[DIV_STAGES-1:0], a_valid_reg};
            p1_valid_reg <= dv_valid_reg[DIV_STAGES];
            p2_valid_reg <= p1_valid_reg;
            m_tvalid_reg <= p2_valid_reg;
        end
    end

    // Payload registers; hold everything on a stall
    always_ff @(posedge aclk) begin
        if (adv) begin
            // Stage A
            a_max_reg    <= (mv_next <= MV_W'(base_mv_reg));
            a_excess_reg <= mv_next - MV_W'(base_mv_reg);
            a_gain_k_reg <= GAIN_K_W'(fit_gain_reg) * GAIN_K_W'(MILLI);
            // Load the numerator with half the divisor for rounding
            dv_reg[0].at_max <= a_max_reg;
            dv_reg[0].dvs    <= a_excess_reg;
            dv_reg[0].rem    <= '0;
            dv_reg[0].nq     <= NUM_W'(a_gain_k_reg) + NUM_W'(a_excess_reg >> 1);
            // Advance the divider
            for (int i = 1; i <= DIV_STAGES; i++) begin
                dv_reg[i] <= dv_next[i];
            end
            // Stage P1
            p1_max_reg  <= dv_reg[DIV_STAGES].at_max;
            p1_zero_reg <= (quot <= QUOT_W'(tap_offset_reg));
            p1_sat_reg  <= (x_next >= SAT_LIMIT);
            p1_x_reg    <= x_next[X_W-1:0];
            // Stage P2
            p2_max_reg  <= p1_max_reg;
            p2_zero_reg <= p1_zero_reg;
            p2_sat_reg  <= p1_sat_reg;
            p2_prod_reg <= PROD_W'(p1_x_reg) * PROD_W'(RECIP);
            // Output
            tap_reg <= tap_next;
        end
    end

endmodule
